[rtl/core/peq_pkg.sv]
// Shared types and constants for the pending event queue.
`timescale 1ns / 1ps

package peq_pkg;

  localparam int NUM_EVENTS = 32;
  localparam int EV_W       = 5;
  localparam int FUNC_W     = 3;
  // Walk step counter: must hold NUM_EVENTS itself
  localparam int CNT_W      = $clog2(NUM_EVENTS + 1);

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ENABLE  = 3'd0,
    FN_DISABLE = 3'd1,
    FN_ABANDON = 3'd2,
    FN_SET     = 3'd3,
    FN_CLEAR   = 3'd4,
    FN_POP     = 3'd5
  } func_t;

  // Per-event status; all bits set means enabled and idle
  typedef enum logic [1:0] {
    ST_DISABLED  = 2'd0,
    ST_PENDING   = 2'd1,
    ST_ABANDONED = 2'd2,
    ST_IDLE      = 2'd3
  } evt_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_WALK_RD,
    S_WALK_CMP,
    S_WALK_FIX,
    S_DONE
  } peq_state_t;

  // Link table port request
  typedef struct packed {
    logic            rd_en;
    logic [EV_W-1:0] rd_addr;
    logic            wr_en;
    logic [EV_W-1:0] wr_addr;
    logic [EV_W-1:0] wr_data;
  } link_req_t;

  // One finished result
  typedef struct packed {
    logic            ok;
    logic            popped_valid;
    logic [EV_W-1:0] popped_event;
    logic            queue_empty;
  } peq_result_t;

endpackage

[rtl/core/pending_event_queue_core.sv]
// Top level of the pending event queue: input handshake and output register.
`timescale 1ns / 1ps

// Pending event queue. Holds 32 events, each disabled, enabled-idle, pending or
// abandoned, with pending events kept in FIFO order in a next-index link table.
// One request is taken at a time. Enable, clear, set, and disable/abandon of a
// non-pending event go from the execute state straight to done; so does a pop that
// empties the queue, while any other pop, like removing the head of a longer queue,
// adds a pop state that loads the new head. Removing a pending event from behind
// the head walks the list, one step per entry ahead of it, plus a fix state to
// relink when it is not the tail. Each walk step needs separate read and compare
// states because the link table has one registered read port.
// A finished result sits in the output register, and the next request is taken
// while it waits. No clearing pass follows reset.
module pending_event_queue_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [peq_pkg::FUNC_W-1:0] func,
  input  logic [peq_pkg::EV_W-1:0]   event_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       ok,
  output logic                       popped_valid,
  output logic [peq_pkg::EV_W-1:0]   popped_event,
  output logic                       queue_empty
);
  import peq_pkg::*;

  logic        ready;
  logic        done;
  logic        start;
  logic        out_free;
  logic        take;
  peq_result_t result;

  assign in_stall = !ready;
  assign start    = in_valid && ready;
  assign out_free = !out_valid || !out_stall;
  assign take     = done && out_free;

  peq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .event_req (event_req),
    .out_free  (out_free),
    .ready     (ready),
    .done      (done),
    .result    (result)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload, loaded on each handover
  always_ff @(posedge clk) begin
    if (take) begin
      ok           <= result.ok;
      popped_valid <= result.popped_valid;
      popped_event <= result.popped_event;
      queue_empty  <= result.queue_empty;
    end
  end

endmodule

[rtl/core/peq_link_mem.sv]
// Next-index link table: one write port, one registered read port.
`timescale 1ns / 1ps

module peq_link_mem (
  input  logic                     clk,
  input  peq_pkg::link_req_t       req,
  output logic [peq_pkg::EV_W-1:0] rd_data
);
  import peq_pkg::*;

  logic [EV_W-1:0] mem [NUM_EVENTS];

  // Single port pair, read data registered
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/core/peq_ctrl.sv]
// Sequencer: event status, list pointers and the list walk over the link table.
`timescale 1ns / 1ps

module peq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [peq_pkg::FUNC_W-1:0] func,
  input  logic [peq_pkg::EV_W-1:0]   event_req,
  input  logic                       out_free,
  output logic                       ready,
  output logic                       done,
  output peq_pkg::peq_result_t       result
);
  import peq_pkg::*;

  peq_state_t      state, state_next;
  func_t           func_r, func_r_next;
  logic [EV_W-1:0] ev_r, ev_r_next;
  evt_status_t     status [NUM_EVENTS];
  logic [EV_W-1:0] head, head_next;
  logic [EV_W-1:0] tail, tail_next;
  logic            list_empty, list_empty_next;
  logic [EV_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] k, k_next;
  logic            ev_is_tail, ev_is_tail_next;
  logic            res_ok, res_ok_next;
  logic            res_pv, res_pv_next;
  logic [EV_W-1:0] res_pe, res_pe_next;

  logic            st_we;
  logic [EV_W-1:0] st_waddr;
  evt_status_t     st_wdata;

  link_req_t       link_req;
  logic [EV_W-1:0] link_rdata;

  logic [EV_W-1:0] cmp_a, cmp_b;
  logic            cmp_hit;
  evt_status_t     st_cur;
  logic            in_range;
  logic            head_last;
  logic            pop_multi;
  logic            unlink_go;
  logic            walk_end;

  peq_link_mem u_link (
    .clk     (clk),
    .req     (link_req),
    .rd_data (link_rdata)
  );

  // Request decode for the execute step
  assign st_cur    = status[ev_r];
  assign in_range  = {1'b0, ev_r} < CNT_W'(NUM_EVENTS);
  assign head_last = (head == tail);
  assign pop_multi = (func_r == FN_POP) && !list_empty && !head_last;
  assign unlink_go = ((func_r == FN_DISABLE) || (func_r == FN_ABANDON)) && in_range &&
                     (st_cur == ST_PENDING) && !list_empty;

  // Shared index comparator used by the walk read and compare states
  always_comb begin
    unique case (state)
      S_WALK_RD: begin
        cmp_a = cur;
        cmp_b = tail;
      end
      S_WALK_CMP: begin
        cmp_a = link_rdata;
        cmp_b = ev_r;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end
  assign cmp_hit  = (cmp_a == cmp_b);
  assign walk_end = cmp_hit || (k == CNT_W'(NUM_EVENTS));

  assign ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign done  = (state == S_DONE);

  assign result.ok           = res_ok;
  assign result.popped_valid = res_pv;
  assign result.popped_event = res_pe;
  assign result.queue_empty  = list_empty;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (pop_multi) begin
          state_next = S_POP;
        end else if (unlink_go && (head == ev_r) && !head_last) begin
          state_next = S_POP;
        end else if (unlink_go && (head != ev_r)) begin
          state_next = S_WALK_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_POP: state_next = S_DONE;
      S_WALK_RD: begin
        state_next = walk_end ? S_DONE : S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (cmp_hit && !ev_is_tail) begin
          state_next = S_WALK_FIX;
        end else if (cmp_hit) begin
          state_next = S_DONE;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_WALK_FIX: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = start ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath updates and link table requests
  always_comb begin
    func_r_next     = func_r;
    ev_r_next       = ev_r;
    head_next       = head;
    tail_next       = tail;
    list_empty_next = list_empty;
    cur_next        = cur;
    k_next          = k;
    ev_is_tail_next = ev_is_tail;
    res_ok_next     = res_ok;
    res_pv_next     = res_pv;
    res_pe_next     = res_pe;
    st_we           = 1'b0;
    st_waddr        = ev_r;
    st_wdata        = ST_DISABLED;
    link_req        = '0;

    if (start) begin
      func_r_next = func_t'(func);
      ev_r_next   = event_req;
    end

    unique case (state)
      S_EXEC: begin
        ev_is_tail_next = (ev_r == tail);
        res_ok_next     = 1'b0;
        res_pv_next     = 1'b0;
        res_pe_next     = '0;
        unique case (func_r)
          FN_POP: begin
            if (!list_empty) begin
              res_pv_next = 1'b1;
              res_pe_next = head;
              st_we       = 1'b1;
              st_waddr    = head;
              st_wdata    = ST_IDLE;
              if (head_last) begin
                list_empty_next = 1'b1;
              end else begin
                link_req.rd_en   = 1'b1;
                link_req.rd_addr = head;
              end
            end
          end
          FN_ENABLE: begin
            if (in_range && (st_cur == ST_DISABLED)) begin
              st_we       = 1'b1;
              st_wdata    = ST_IDLE;
              res_ok_next = 1'b1;
            end
          end
          FN_DISABLE, FN_ABANDON: begin
            if (in_range && (st_cur != ST_DISABLED)) begin
              st_we       = 1'b1;
              st_wdata    = (func_r == FN_ABANDON) ? ST_ABANDONED : ST_DISABLED;
              res_ok_next = 1'b1;
              if (unlink_go) begin
                if (head == ev_r) begin
                  if (head_last) begin
                    list_empty_next = 1'b1;
                  end else begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = ev_r;
                  end
                end else begin
                  cur_next = head;
                  k_next   = '0;
                end
              end
            end
          end
          FN_SET: begin
            if (in_range && (st_cur == ST_IDLE)) begin
              st_we       = 1'b1;
              st_wdata    = ST_PENDING;
              res_ok_next = 1'b1;
              tail_next   = ev_r;
              if (list_empty) begin
                head_next       = ev_r;
                list_empty_next = 1'b0;
              end else begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = tail;
                link_req.wr_data = ev_r;
              end
            end
          end
          FN_CLEAR: begin
            if (in_range && (st_cur == ST_ABANDONED)) begin
              st_we       = 1'b1;
              st_wdata    = ST_DISABLED;
              res_ok_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      // New head arrives from the link table
      S_POP: head_next = link_rdata;
      S_WALK_RD: begin
        if (!walk_end) begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = cur;
        end
      end
      S_WALK_CMP: begin
        if (cmp_hit) begin
          if (ev_is_tail) begin
            tail_next = cur;
          end else begin
            link_req.rd_en   = 1'b1;
            link_req.rd_addr = ev_r;
          end
        end else begin
          cur_next = link_rdata;
          k_next   = k + CNT_W'(1);
        end
      end
      // Predecessor skips over the removed event
      S_WALK_FIX: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = cur;
        link_req.wr_data = link_rdata;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      list_empty <= 1'b1;
      k          <= '0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
        status[i] <= ST_DISABLED;
      end
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      list_empty <= list_empty_next;
      k          <= k_next;
      if (st_we) begin
        status[st_waddr] <= st_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_r_next;
    ev_r       <= ev_r_next;
    cur        <= cur_next;
    ev_is_tail <= ev_is_tail_next;
    res_ok     <= res_ok_next;
    res_pv     <= res_pv_next;
    res_pe     <= res_pe_next;
  end

  // Between requests, both list ends are pending events
  a_head_pending: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) || (state == S_DONE)) && !list_empty |-> status[head] == ST_PENDING)
    else $error("queue head is not pending");

  a_tail_pending: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) || (state == S_DONE)) && !list_empty |-> status[tail] == ST_PENDING)
    else $error("queue tail is not pending");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_CMP) |-> (k < CNT_W'(NUM_EVENTS)))
    else $error("list walk ran past its bound");

  a_pop_no_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && res_pv |-> !res_ok)
    else $error("pop result also flags ok");

endmodule
